// ===== rtl/svm_pkg.sv =====
// shared types, codes and constants of the sample playback voice mixer
package svm_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRAME_DEPTH_DEF = 65536;
  localparam int QUEUE_DEPTH     = 2;
  localparam int POS_W           = 33;
  localparam int FRAME_W         = 17;
  localparam int SPEED_W         = 24;
  localparam int VOL_W           = 16;
  localparam int LOOP_W          = 16;
  localparam int FC_W            = 17;
  localparam int ADDR_IN_W       = 16;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int OP_W            = 3;
  localparam int WORD_W          = 2 * SAMPLE_BITS;

  localparam logic signed [SPEED_W-1:0] SPEED_RST = 24'sd65536;
  localparam logic [VOL_W-1:0]          VOL_RST   = 16'd16384;
  localparam logic [LOOP_W-1:0]         LSTART_RST = 16'd0;
  localparam logic [LOOP_W-1:0]         LEND_RST   = 16'd65535;
  localparam logic                      STOP_RST   = 1'b1;
  localparam logic [FC_W-1:0]           FC_RST     = 17'd0;

  typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
  typedef logic signed [POS_W-1:0]       pos_t;
  typedef logic signed [FRAME_W-1:0]     frame_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]         cfg_data_t;
  typedef logic [OP_W-1:0]               op_code_t;

  typedef enum logic [OP_W-1:0] {
    OP_MIX      = 3'd0,
    OP_WRITE    = 3'd1,
    OP_SET_POS  = 3'd2,
    OP_SET_PLAY = 3'd3,
    OP_TOGGLE   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED       = 3'd0,
    REG_VOLUME      = 3'd1,
    REG_LOOP_ENABLE = 3'd2,
    REG_LOOP_START  = 3'd3,
    REG_LOOP_END    = 3'd4,
    REG_STOP_ON_END = 3'd5,
    REG_FRAME_COUNT = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_MIX,
    CMD_WRITE,
    CMD_SET_POS,
    CMD_SET_PLAY,
    CMD_TOGGLE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    pcm_t                   samp_l;
    pcm_t                   samp_r;
    logic                   first;
    logic                   last;
    pos_t                   new_pos;
    logic [ADDR_IN_W-1:0]   waddr;
    logic                   play_flag;
  } cmd_t;

  typedef struct packed {
    logic    do_mix;
    pcm_t    samp_l;
    pcm_t    samp_r;
    logic    playing;
    frame_t  pos_frame;
    logic    ended;
  } ctx_t;

endpackage

// ===== rtl/svm_chan_if.sv =====
// valid/ready channel interfaces for the input items and the result items

interface svm_in_if;
  import svm_pkg::*;

  logic                 valid;
  logic                 ready;
  op_code_t             operation;
  pcm_t                 sample_left;
  pcm_t                 sample_right;
  logic                 first_of_block;
  logic                 last_of_block;
  pos_t                 new_position;
  logic [ADDR_IN_W-1:0] write_address;
  logic                 play_flag;

  modport source (
    output valid, operation, sample_left, sample_right, first_of_block,
           last_of_block, new_position, write_address, play_flag,
    input  ready
  );

  modport sink (
    input  valid, operation, sample_left, sample_right, first_of_block,
           last_of_block, new_position, write_address, play_flag,
    output ready
  );
endinterface

interface svm_out_if;
  import svm_pkg::*;

  logic    valid;
  logic    ready;
  pcm_t    out_left;
  pcm_t    out_right;
  logic    playing_now;
  frame_t  position_frame;
  logic    ended_now;

  modport source (
    output valid, out_left, out_right, playing_now, position_frame, ended_now,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right, playing_now, position_frame, ended_now,
    output ready
  );
endinterface

// ===== rtl/svm_front.sv =====
// front end: accepts input transactions, decodes them and queues commands
module svm_front (
  input  logic           clk,
  input  logic           rst_n,
  svm_in_if.sink         in_ch,
  output svm_pkg::cmd_t  q_cmd,
  output logic           q_valid,
  input  logic           q_ready
);
  import svm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            q_mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  cmd_t            dec_cmd;
  logic            push, pop;

  // classify the incoming transaction
  always_comb begin
    dec_cmd.samp_l    = in_ch.sample_left;
    dec_cmd.samp_r    = in_ch.sample_right;
    dec_cmd.first     = in_ch.first_of_block;
    dec_cmd.last      = in_ch.last_of_block;
    dec_cmd.new_pos   = in_ch.new_position;
    dec_cmd.waddr     = in_ch.write_address;
    dec_cmd.play_flag = in_ch.play_flag;
    case (in_ch.operation)
      OP_MIX:      dec_cmd.kind = CMD_MIX;
      OP_WRITE:    dec_cmd.kind = CMD_WRITE;
      OP_SET_POS:  dec_cmd.kind = CMD_SET_POS;
      OP_SET_PLAY: dec_cmd.kind = CMD_SET_PLAY;
      OP_TOGGLE:   dec_cmd.kind = CMD_TOGGLE;
      default:     dec_cmd.kind = CMD_NOP;
    endcase
  end

  assign in_ch.ready = (count_r != CW'(QUEUE_DEPTH));
  assign q_valid     = (count_r != '0);
  assign q_cmd       = q_mem[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

// ===== rtl/svm_exec.sv =====
// back end: configuration, voice state update and the sample store
module svm_exec #(
  parameter int FRAME_DEPTH = svm_pkg::FRAME_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  svm_pkg::cfg_idx_t                  cfg_index,
  input  svm_pkg::cfg_data_t                 cfg_data,
  input  svm_pkg::cmd_t                      q_cmd,
  input  logic                               q_valid,
  output logic                               q_ready,
  output svm_pkg::ctx_t                      ctx,
  output logic                               ctx_valid,
  input  logic                               ctx_ready,
  output logic [2*svm_pkg::SAMPLE_BITS-1:0]  rd_data,
  output logic [svm_pkg::VOL_W-1:0]          volume
);
  import svm_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int EW = (AW > ADDR_IN_W) ? AW : ADDR_IN_W;
  localparam int ALLOW_HI_W = POS_W + 2 - 16;

  // configuration registers
  logic signed [SPEED_W-1:0] speed_r;
  logic [VOL_W-1:0]          volume_r;
  logic                      loop_en_r;
  logic [LOOP_W-1:0]         loop_start_r;
  logic [LOOP_W-1:0]         loop_end_r;
  logic                      stop_r;
  logic [FC_W-1:0]           fc_r;

  // voice state
  pos_t              pos_r, pos_nxt;
  logic              playing_r, playing_nxt;
  logic              ended_r, ended_nxt;
  logic [FC_W-1:0]   fa_r, fa_nxt;

  logic              ctx_v_r;
  ctx_t              ctx_r;
  logic [WORD_W-1:0] store_mem [FRAME_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  logic                       q_fire;
  logic                       do_mix;
  pcm_t                       samp_l, samp_r;
  logic signed [POS_W+1:0]    diff;
  logic [ALLOW_HI_W-1:0]      allow_raw;
  logic [FC_W-1:0]            allow;
  frame_t                     idx;
  logic                       idx_neg, idx_ge_fc;
  logic                       spd_neg, spd_pos;
  logic signed [POS_W:0]      step_sum;
  pos_t                       pos_sat, pos_step, loop_lo, loop_hi;
  logic                       end_hit;
  logic [EW-1:0]              rd_ext, wr_ext;
  logic                       mem_we;

  assign q_ready   = !ctx_v_r || ctx_ready;
  assign q_fire    = q_valid && q_ready;
  assign ctx       = ctx_r;
  assign ctx_valid = ctx_v_r;
  assign rd_data   = rd_data_r;
  assign volume    = volume_r;

  // frames left to the end of the sample at block start
  assign diff      = $signed({2'b00, fc_r, 16'h0000}) - (POS_W+2)'(pos_r);
  assign allow_raw = (!diff[POS_W+1] && diff != '0) ? diff[POS_W+1:16] : '0;
  assign allow     = (|allow_raw[ALLOW_HI_W-1:FC_W]) ? '1 : allow_raw[FC_W-1:0];

  // store index: position truncated toward zero
  assign idx       = pos_r[POS_W-1:16] + FRAME_W'(pos_r[POS_W-1] && (|pos_r[15:0]));
  assign idx_neg   = idx[FRAME_W-1];
  assign idx_ge_fc = !idx_neg && ({1'b0, idx[FRAME_W-2:0]} >= fc_r);

  assign spd_neg   = speed_r[SPEED_W-1];
  assign spd_pos   = !spd_neg && (speed_r != '0);
  assign end_hit   = (spd_neg && idx_neg) || (spd_pos && idx_ge_fc);

  // position step with saturation, then loop wrap
  assign step_sum = (POS_W+1)'(pos_r) + (POS_W+1)'(speed_r);
  always_comb begin
    if (step_sum[POS_W] != step_sum[POS_W-1]) begin
      pos_sat = step_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_sat = step_sum[POS_W-1:0];
    end
  end

  assign loop_lo = {1'b0, loop_start_r, 16'h0000};
  assign loop_hi = {1'b0, loop_end_r, 16'h0000};

  always_comb begin
    pos_step = pos_sat;
    if (loop_en_r) begin
      if (spd_neg && (pos_sat < loop_lo)) begin
        pos_step = loop_hi;
      end else if (spd_pos && (pos_sat > loop_hi)) begin
        pos_step = loop_lo;
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    playing_nxt = playing_r;
    ended_nxt   = ended_r;
    fa_nxt      = fa_r;
    do_mix      = 1'b0;
    samp_l      = '0;
    samp_r      = '0;
    if (q_fire) begin
      case (q_cmd.kind)
        CMD_MIX: begin
          samp_l = q_cmd.samp_l;
          samp_r = q_cmd.samp_r;
          if (q_cmd.first) begin
            ended_nxt = 1'b0;
            fa_nxt    = '0;
            if (playing_r) begin
              fa_nxt = allow;
              if (allow == '0) begin
                playing_nxt = 1'b0;
              end
            end
          end
          if (fa_nxt != '0) begin
            fa_nxt = fa_nxt - 1'b1;
            if (!(ended_nxt && stop_r)) begin
              pos_nxt = pos_step;
              if (end_hit) begin
                ended_nxt = 1'b1;
              end else if (!idx_neg && !idx_ge_fc) begin
                do_mix = 1'b1;
              end
            end
          end
          if (q_cmd.last) begin
            if (ended_nxt && stop_r) begin
              playing_nxt = 1'b0;
            end
            fa_nxt = '0;
          end
        end
        CMD_SET_POS: begin
          pos_nxt = q_cmd.new_pos;
        end
        CMD_SET_PLAY: begin
          playing_nxt = q_cmd.play_flag;
        end
        CMD_TOGGLE: begin
          playing_nxt = !playing_r;
        end
        default: begin
          pos_nxt = pos_r;
        end
      endcase
    end
  end

  // depth is a power of two, so the store index wraps by masking
  assign rd_ext = EW'(idx[FRAME_W-2:0]);
  assign wr_ext = EW'(q_cmd.waddr);
  assign mem_we = q_fire && (q_cmd.kind == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_ext[AW-1:0]] <= {q_cmd.samp_r, q_cmd.samp_l};
    end
    if (do_mix) begin
      rd_data_r <= store_mem[rd_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r      <= SPEED_RST;
      volume_r     <= VOL_RST;
      loop_en_r    <= 1'b0;
      loop_start_r <= LSTART_RST;
      loop_end_r   <= LEND_RST;
      stop_r       <= STOP_RST;
      fc_r         <= FC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED:       speed_r      <= cfg_data[SPEED_W-1:0];
        REG_VOLUME:      volume_r     <= cfg_data[VOL_W-1:0];
        REG_LOOP_ENABLE: loop_en_r    <= cfg_data[0];
        REG_LOOP_START:  loop_start_r <= cfg_data[LOOP_W-1:0];
        REG_LOOP_END:    loop_end_r   <= cfg_data[LOOP_W-1:0];
        REG_STOP_ON_END: stop_r       <= cfg_data[0];
        REG_FRAME_COUNT: fc_r         <= cfg_data[FC_W-1:0];
        default:         stop_r       <= stop_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      playing_r <= 1'b0;
      ended_r   <= 1'b0;
      fa_r      <= '0;
      ctx_v_r   <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      playing_r <= playing_nxt;
      ended_r   <= ended_nxt;
      fa_r      <= fa_nxt;
      if (q_fire) begin
        ctx_v_r <= 1'b1;
      end else if (ctx_ready) begin
        ctx_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_fire) begin
      ctx_r.do_mix    <= do_mix;
      ctx_r.samp_l    <= samp_l;
      ctx_r.samp_r    <= samp_r;
      ctx_r.playing   <= playing_nxt;
      ctx_r.pos_frame <= pos_nxt[POS_W-1:16];
      ctx_r.ended     <= ended_nxt;
    end
  end

endmodule

// ===== rtl/svm_mix.sv =====
// mix stage: on do_mix adds volume-scaled stored frames, saturates; holds result
module svm_mix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  svm_pkg::ctx_t                      ctx,
  input  logic                               ctx_valid,
  output logic                               ctx_ready,
  input  logic [2*svm_pkg::SAMPLE_BITS-1:0]  rd_data,
  input  logic [svm_pkg::VOL_W-1:0]          volume,
  svm_out_if.source                          out_ch
);
  import svm_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + VOL_W + 1;
  localparam int NUM_W  = PROD_W + 2;
  localparam int QUO_W  = NUM_W - 14;
  localparam logic signed [QUO_W-1:0] SAT_HI = QUO_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QUO_W-1:0] SAT_LO = QUO_W'(-(1 <<< (SAMPLE_BITS - 1)));

  function automatic pcm_t mix_one(pcm_t smp_in, pcm_t stored,
                                   logic [VOL_W-1:0] vol);
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  num;
    logic signed [QUO_W-1:0]  quo;
    prod = stored * $signed({1'b0, vol});
    num  = (NUM_W'(smp_in) <<< 14) + NUM_W'(prod);
    // divide by 2^14 rounding toward zero
    if (num[NUM_W-1]) begin
      quo = QUO_W'((num + NUM_W'(16383)) >>> 14);
    end else begin
      quo = QUO_W'(num >>> 14);
    end
    if (quo > SAT_HI) begin
      mix_one = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quo < SAT_LO) begin
      mix_one = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      mix_one = quo[SAMPLE_BITS-1:0];
    end
  endfunction

  logic    out_v_r;
  pcm_t    left_r, right_r;
  logic    playing_r, ended_r;
  frame_t  pos_frame_r;
  pcm_t    left_nxt, right_nxt;
  logic    take;

  assign ctx_ready = !out_v_r || out_ch.ready;
  assign take      = ctx_valid && ctx_ready;

  always_comb begin
    if (ctx.do_mix) begin
      left_nxt  = mix_one(ctx.samp_l, rd_data[SAMPLE_BITS-1:0], volume);
      right_nxt = mix_one(ctx.samp_r, rd_data[WORD_W-1:SAMPLE_BITS], volume);
    end else begin
      left_nxt  = ctx.samp_l;
      right_nxt = ctx.samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      playing_r   <= ctx.playing;
      pos_frame_r <= ctx.pos_frame;
      ended_r     <= ctx.ended;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_left       = left_r;
  assign out_ch.out_right      = right_r;
  assign out_ch.playing_now    = playing_r;
  assign out_ch.position_frame = pos_frame_r;
  assign out_ch.ended_now      = ended_r;

endmodule

// ===== rtl/sample_playback_voice_mixer.sv =====
// One stereo voice that plays a stored sample at a signed Q8.16 speed and mixes it, scaled
// by a Q2.14 volume with 16-bit saturation, into the incoming frame stream; write, set
// position, set playing and toggle transactions drive the voice and the sample store, and
// every input transaction gives exactly one result. A two-entry command queue sits between
// the input decode and the voice state stage, and an output register follows the mix stage,
// so one transaction is taken per clock while the output is drained; the voice state update
// registers its context together with the store read, and the volume multiply is combinational
// ahead of the output register. FRAME_DEPTH must be a power of two; reading a store entry
// that was never written gives undefined sample data.
module sample_playback_voice_mixer #(
  parameter int FRAME_DEPTH = svm_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  svm_pkg::cfg_idx_t  cfg_index,
  input  svm_pkg::cfg_data_t cfg_data,
  svm_in_if.sink             in_ch,
  svm_out_if.source          out_ch
);
  import svm_pkg::*;

  cmd_t              q_cmd;
  logic              q_valid, q_ready;
  ctx_t              ctx;
  logic              ctx_valid, ctx_ready;
  logic [WORD_W-1:0] rd_data;
  logic [VOL_W-1:0]  volume;

  svm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  svm_exec #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_cmd     (q_cmd),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .ctx       (ctx),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .rd_data   (rd_data),
    .volume    (volume)
  );

  svm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctx       (ctx),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .rd_data   (rd_data),
    .volume    (volume),
    .out_ch    (out_ch)
  );

endmodule
